/* rtl/c2s_pkg.sv */
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared widths, payload types and the arctangent table of the converter.
// ----------------------------------------------------------------------------
package c2s_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int ANGLE_WIDTH = 24;
    localparam int GUARD       = 28;
    localparam int CORDIC_ITER = 32;
    localparam int DW          = 56;       // CORDIC datapath width
    localparam int SQ_W        = 50;       // sum of three squares
    localparam int SQRT_STEPS  = 25;       // one result bit per stage
    localparam int LATENCY     = 66;       // pipeline depth in cycles
    localparam logic signed [31:0] KGAIN_Q30 = 32'sd1768195363;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
        logic signed [COORD_WIDTH-1:0] z_coord;
    } c2s_in_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0]        radius;
        logic signed [ANGLE_WIDTH-1:0] elevation;
        logic signed [ANGLE_WIDTH-1:0] azimuth;
        logic                          zero_vector;
    } c2s_out_t;

    function automatic logic [31:0] atan_tab(input logic [4:0] i);
        logic [31:0] t;
        unique case (i)
            5'd0:  t = 32'd536870912;
            5'd1:  t = 32'd316933406;
            5'd2:  t = 32'd167458907;
            5'd3:  t = 32'd85004756;
            5'd4:  t = 32'd42667331;
            5'd5:  t = 32'd21354465;
            5'd6:  t = 32'd10679838;
            5'd7:  t = 32'd5340245;
            5'd8:  t = 32'd2670163;
            5'd9:  t = 32'd1335087;
            5'd10: t = 32'd667544;
            5'd11: t = 32'd333772;
            5'd12: t = 32'd166886;
            5'd13: t = 32'd83443;
            5'd14: t = 32'd41722;
            5'd15: t = 32'd20861;
            5'd16: t = 32'd10430;
            5'd17: t = 32'd5215;
            5'd18: t = 32'd2608;
            5'd19: t = 32'd1304;
            5'd20: t = 32'd652;
            5'd21: t = 32'd326;
            5'd22: t = 32'd163;
            5'd23: t = 32'd81;
            5'd24: t = 32'd41;
            5'd25: t = 32'd20;
            5'd26: t = 32'd10;
            5'd27: t = 32'd5;
            5'd28: t = 32'd3;
            5'd29: t = 32'd1;
            5'd30: t = 32'd1;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage

/* rtl/c2s_if.sv */
// ----------------------------------------------------------------------------
// c2s_in_if / c2s_out_if
// Valid/ready channels carrying the vector and the spherical result.
// ----------------------------------------------------------------------------
interface c2s_in_if;
    logic                          valid;
    logic                          ready;
    logic signed [c2s_pkg::COORD_WIDTH-1:0] x_coord;
    logic signed [c2s_pkg::COORD_WIDTH-1:0] y_coord;
    logic signed [c2s_pkg::COORD_WIDTH-1:0] z_coord;
    modport source (output valid, x_coord, y_coord, z_coord, input ready);
    modport sink   (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

interface c2s_out_if;
    logic                          valid;
    logic                          ready;
    logic [c2s_pkg::COORD_WIDTH-1:0]        radius;
    logic signed [c2s_pkg::ANGLE_WIDTH-1:0] elevation;
    logic signed [c2s_pkg::ANGLE_WIDTH-1:0] azimuth;
    logic                          zero_vector;
    modport source (output valid, radius, elevation, azimuth, zero_vector, input ready);
    modport sink   (input valid, radius, elevation, azimuth, zero_vector, output ready);
endinterface

/* rtl/cartesian_to_spherical.sv */
// Throughput: one beat per cycle while the output is not stalled; 1 prepare stage, 32 azimuth CORDIC stages,
// 1 load stage and 32 elevation CORDIC stages set the depth.
// Stalls: the whole pipeline holds when a valid result beat is not taken.
// Reset: asynchronous, active low; clears only the stage valid bits.
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// Pipelined vector to radius/elevation/azimuth converter.
// ----------------------------------------------------------------------------
module cartesian_to_spherical (
    input  logic   clk,
    input  logic   rst_n,
    c2s_in_if.sink   in_ch,
    c2s_out_if.source out_ch
);
    import c2s_pkg::*;

    localparam int NS   = CORDIC_ITER + 1;   // front stages 1..NS
    localparam int ZM_W = COORD_WIDTH + 32;  // z times gain

    // Front stages. Stage 1 prepares; stages 2..33 run azimuth step s-2.
    // The square root runs alongside in stages 2..26, then the remainder
    // and root ride along to stage 33.
    logic                  v_reg   [NS+1];
    logic signed [DW-1:0]  ax_reg  [NS+1];  // azimuth x
    logic signed [DW-1:0]  ay_reg  [NS+1];
    logic [31:0]           aa_reg  [NS+1];
    logic signed [DW-1:0]  zk_reg  [NS+1];
    logic [1:0]            cls_reg [NS+1];  // 0 normal, 1 z axis, 2 zero
    logic                  zs_reg  [NS+1];  // z sign
    // square root state
    logic [SQ_W-1:0]       rem_reg [NS+1];
    logic [SQ_W-1:0]       res_reg [NS+1];

    localparam logic [1:0] CLS_NORM = 2'd0;
    localparam logic [1:0] CLS_ZAX  = 2'd1;
    localparam logic [1:0] CLS_ZERO = 2'd2;

    // Elevation CORDIC: its own stages fed by the final azimuth x.
    logic                 ev_v_reg  [CORDIC_ITER+1];
    logic signed [DW-1:0] evx_reg   [CORDIC_ITER+1];
    logic signed [DW-1:0] evy_reg   [CORDIC_ITER+1];
    logic [31:0]          eva_reg   [CORDIC_ITER+1];
    c2s_out_t             evp_reg   [CORDIC_ITER+1];
    logic [1:0]           evc_reg   [CORDIC_ITER+1];
    logic                 evz_reg   [CORDIC_ITER+1];

    // One enable for every stage: move on unless a result beat is stuck
    logic adv;
    assign adv = out_ch.ready || !ev_v_reg[CORDIC_ITER];
    assign in_ch.ready = adv;

    function automatic logic [SQ_W-1:0] sq_bit(input int k);
        return SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    endfunction

    // Stage 0 combinational inputs
    logic signed [DW-1:0] x0, y0;
    logic [SQ_W-1:0] sum0;
    logic [COORD_WIDTH-1:0] mx, my, mz;
    logic [2*COORD_WIDTH-1:0] px2, py2, pz2;
    always_comb
    begin
        x0 = DW'(in_ch.x_coord);
        y0 = DW'(in_ch.y_coord);
        mx = in_ch.x_coord[COORD_WIDTH-1] ? COORD_WIDTH'(-in_ch.x_coord) : in_ch.x_coord;
        my = in_ch.y_coord[COORD_WIDTH-1] ? COORD_WIDTH'(-in_ch.y_coord) : in_ch.y_coord;
        mz = in_ch.z_coord[COORD_WIDTH-1] ? COORD_WIDTH'(-in_ch.z_coord) : in_ch.z_coord;
        px2 = mx * mx;
        py2 = my * my;
        pz2 = mz * mz;
        sum0 = SQ_W'(px2) + SQ_W'(py2) + SQ_W'(pz2);
    end

    // Stage 1: pre-rotation, gain on z, square sum
    logic signed [ZM_W-1:0] zmul;
    assign zmul = ZM_W'(in_ch.z_coord) * ZM_W'(KGAIN_Q30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= NS; s++) v_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[1] <= in_ch.valid;
            for (int s = 2; s <= NS; s++) v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (in_ch.x_coord[COORD_WIDTH-1])
            begin
                ax_reg[1] <= -(x0 <<< GUARD);
                ay_reg[1] <= -(y0 <<< GUARD);
                aa_reg[1] <= 32'h8000_0000;
            end
            else
            begin
                ax_reg[1] <= x0 <<< GUARD;
                ay_reg[1] <= y0 <<< GUARD;
                aa_reg[1] <= 32'd0;
            end
            zk_reg[1] <= DW'(zmul >>> (30 - GUARD));
            zs_reg[1] <= in_ch.z_coord[COORD_WIDTH-1];
            if (in_ch.x_coord == '0 && in_ch.y_coord == '0)
                cls_reg[1] <= (in_ch.z_coord == '0) ? CLS_ZERO : CLS_ZAX;
            else
                cls_reg[1] <= CLS_NORM;
            rem_reg[1] <= sum0;
            res_reg[1] <= '0;

            for (int s = 2; s <= NS; s++)
            begin
                cls_reg[s] <= cls_reg[s-1];
                zs_reg[s]  <= zs_reg[s-1];
                zk_reg[s]  <= zk_reg[s-1];
                // azimuth step s-2
                if (!ay_reg[s-1][DW-1])
                begin
                    ax_reg[s] <= ax_reg[s-1] + (ay_reg[s-1] >>> (s-2));
                    ay_reg[s] <= ay_reg[s-1] - (ax_reg[s-1] >>> (s-2));
                    aa_reg[s] <= aa_reg[s-1] + atan_tab(5'(s-2));
                end
                else
                begin
                    ax_reg[s] <= ax_reg[s-1] - (ay_reg[s-1] >>> (s-2));
                    ay_reg[s] <= ay_reg[s-1] + (ax_reg[s-1] >>> (s-2));
                    aa_reg[s] <= aa_reg[s-1] - atan_tab(5'(s-2));
                end
                // square root: one result bit per stage
                if (s - 2 < SQRT_STEPS)
                begin
                    if (rem_reg[s-1] >= res_reg[s-1] + sq_bit(s - 2))
                    begin
                        rem_reg[s] <= rem_reg[s-1] - (res_reg[s-1] + sq_bit(s - 2));
                        res_reg[s] <= (res_reg[s-1] >> 1) + sq_bit(s - 2);
                    end
                    else
                    begin
                        rem_reg[s] <= rem_reg[s-1];
                        res_reg[s] <= res_reg[s-1] >> 1;
                    end
                end
                else
                begin
                    rem_reg[s] <= rem_reg[s-1];
                    res_reg[s] <= res_reg[s-1];
                end
            end
        end
    end

    // Radius rounding and azimuth rounding, both on the last front stage
    logic [SQ_W-1:0] rad_full;
    logic [31:0] az_rnd;

    always_comb
    begin
        rad_full = (rem_reg[NS] > res_reg[NS]) ? res_reg[NS] + SQ_W'(1) : res_reg[NS];
        az_rnd   = aa_reg[NS] + (32'd1 << (31 - ANGLE_WIDTH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= CORDIC_ITER; s++) ev_v_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            ev_v_reg[0] <= v_reg[NS];
            for (int s = 1; s <= CORDIC_ITER; s++) ev_v_reg[s] <= ev_v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            evx_reg[0] <= ax_reg[NS];
            evy_reg[0] <= zk_reg[NS];
            eva_reg[0] <= '0;
            evc_reg[0] <= cls_reg[NS];
            evz_reg[0] <= zs_reg[NS];
            evp_reg[0].radius      <= rad_full[COORD_WIDTH-1:0];
            evp_reg[0].azimuth     <= (cls_reg[NS] == CLS_NORM)
                                      ? az_rnd[31 -: ANGLE_WIDTH] : '0;
            evp_reg[0].elevation   <= '0;
            evp_reg[0].zero_vector <= (cls_reg[NS] == CLS_ZERO);
            for (int s = 1; s <= CORDIC_ITER; s++)
            begin
                evc_reg[s] <= evc_reg[s-1];
                evz_reg[s] <= evz_reg[s-1];
                evp_reg[s] <= evp_reg[s-1];
                if (!evy_reg[s-1][DW-1])
                begin
                    evx_reg[s] <= evx_reg[s-1] + (evy_reg[s-1] >>> (s-1));
                    evy_reg[s] <= evy_reg[s-1] - (evx_reg[s-1] >>> (s-1));
                    eva_reg[s] <= eva_reg[s-1] + atan_tab(5'(s-1));
                end
                else
                begin
                    evx_reg[s] <= evx_reg[s-1] - (evy_reg[s-1] >>> (s-1));
                    evy_reg[s] <= evy_reg[s-1] + (evx_reg[s-1] >>> (s-1));
                    eva_reg[s] <= eva_reg[s-1] - atan_tab(5'(s-1));
                end
            end
        end
    end

    // Output: clamp the elevation to a quarter turn, then round.
    // Poles and the zero vector override the CORDIC angle.
    logic signed [33:0] e_cl, e_r;
    logic signed [ANGLE_WIDTH-1:0] el_fin;
    localparam logic signed [33:0] QTR32 = 34'sd1 <<< 30;
    localparam logic signed [ANGLE_WIDTH-1:0] QTR =
        ANGLE_WIDTH'(1) <<< (ANGLE_WIDTH - 2);
    always_comb
    begin
        e_cl = 34'(signed'(eva_reg[CORDIC_ITER]));
        if (e_cl > QTR32)  e_cl = QTR32;
        if (e_cl < -QTR32) e_cl = -QTR32;
        e_r = (e_cl + 34'sd2**(31 - ANGLE_WIDTH)) >>> (32 - ANGLE_WIDTH);
        el_fin = e_r[ANGLE_WIDTH-1:0];
        unique case (evc_reg[CORDIC_ITER])
            CLS_ZAX:  el_fin = evz_reg[CORDIC_ITER] ? -QTR : QTR;
            CLS_ZERO: el_fin = '0;
            default:  el_fin = e_r[ANGLE_WIDTH-1:0];
        endcase
    end

    assign out_ch.valid       = ev_v_reg[CORDIC_ITER];
    assign out_ch.radius      = evp_reg[CORDIC_ITER].radius;
    assign out_ch.azimuth     = evp_reg[CORDIC_ITER].azimuth;
    assign out_ch.zero_vector = evp_reg[CORDIC_ITER].zero_vector;
    assign out_ch.elevation   = el_fin;

endmodule

/* rtl/c2s_checker.sv */
// ----------------------------------------------------------------------------
// c2s_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module c2s_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic [c2s_pkg::COORD_WIDTH-1:0] radius,
    input logic [c2s_pkg::ANGLE_WIDTH-1:0] elevation,
    input logic [c2s_pkg::ANGLE_WIDTH-1:0] azimuth,
    input logic zero_vector
);
    import c2s_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(radius))
        else $error("result beat dropped while stalled");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_vector |-> radius == '0 && elevation == '0 && azimuth == '0)
        else $error("zero vector with nonzero fields");

    a_rad0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && radius == '0 |-> zero_vector)
        else $error("zero radius without flag");
endmodule

bind cartesian_to_spherical c2s_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .radius(out_ch.radius), .elevation(out_ch.elevation),
    .azimuth(out_ch.azimuth), .zero_vector(out_ch.zero_vector)
);
